/* design/hcb_pkg.sv */
// Huffman code builder: shared constants, field widths and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package hcb_pkg;
    localparam int MAX_SYMBOLS_DEF = 32;
    localparam int SYM_W    = 8;
    localparam int WEIGHT_W = 16;
    localparam int CODE_W   = 31;
    localparam int LEN_W    = 5;
    localparam int STAT_W   = 2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SINGLE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DROP   = 2'd2;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan_run;
        logic pick_a;
        logic pick_b;
        logic emit_start;
        logic walk_start;
        logic walk_rd;
        logic walk_upd;
        logic out_push;
        logic next_leaf;
        logic done_clear;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic build_done;
        logic c_has_parent;
        logic leaf_last;
        logic out_free;
    } t_stat;
endpackage

/* design/hcb_ctrl.sv */
// Huffman code builder controller: sequences load, tree merges and code walk.
// Depends on hcb_pkg.
`timescale 1ns / 1ps
module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_SCAN_A, S_PICK_A, S_SCAN_B, S_PICK_B,
        S_WALK_START, S_WALK, S_WALK_UPD, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_SCAN_A;
            end
            S_SCAN_A: begin
                if (i_stat.build_done) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_WALK_START;
                end else if (i_stat.scan_done) begin
                    n_state = S_PICK_A;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            S_PICK_A: begin
                o_cmd.pick_a = 1'b1;
                n_state      = S_SCAN_B;
            end
            S_SCAN_B: begin
                if (i_stat.scan_done) begin
                    n_state = S_PICK_B;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            S_PICK_B: begin
                o_cmd.pick_b = 1'b1;
                n_state      = S_SCAN_A;
            end
            S_WALK_START: begin
                o_cmd.walk_start = 1'b1;
                n_state          = S_WALK;
            end
            S_WALK: begin
                if (i_stat.c_has_parent) begin
                    o_cmd.walk_rd = 1'b1;
                    n_state       = S_WALK_UPD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WALK_UPD: begin
                o_cmd.walk_upd = 1'b1;
                n_state        = S_WALK;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_push = 1'b1;
                    if (i_stat.leaf_last) begin
                        o_cmd.done_clear = 1'b1;
                        n_state          = S_LOAD;
                    end else begin
                        o_cmd.next_leaf = 1'b1;
                        n_state         = S_WALK_START;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end
endmodule

/* design/hcb_dp.sv */
// Huffman code builder datapath: leaf and tree memories, min scan,
// code walk and output register. Depends on hcb_pkg.
`timescale 1ns / 1ps
module hcb_dp
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic [WEIGHT_W-1:0] i_weight,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SYM_W-1:0]    o_symbol,
    output logic [CODE_W-1:0]   o_code,
    output logic [LEN_W-1:0]    o_len,
    output logic [STAT_W-1:0]   o_status,
    output logic                o_final
);
    localparam int NODES  = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W  = $clog2(NODES);
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int SYM_AW = $clog2(MAX_SYMBOLS);
    localparam int WT_W   = WEIGHT_W + $clog2(MAX_SYMBOLS);

    logic [SYM_W-1:0]  m_sym    [MAX_SYMBOLS];
    logic [WT_W-1:0]   m_weight [NODES];
    logic [IDX_W:0]    m_parent [NODES];

    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [NODES-1:0]  r_hp;
    logic [IDX_W-1:0]  r_node, r_scan, r_rd_idx, r_best, r_c;
    logic              r_rd_vld, r_found;
    logic [WT_W-1:0]   r_rd_w, r_best_w, r_a_w;
    logic [CNT_W-1:0]  r_leaf;
    logic [SYM_W-1:0]  r_sym;
    logic [IDX_W:0]    r_par;
    logic [CODE_W-1:0] r_code;
    logic [LEN_W-1:0]  r_len;

    logic              wt_we;
    logic [IDX_W-1:0]  wt_wa;
    logic [WT_W-1:0]   wt_wd;
    logic              scan_issue;
    logic [IDX_W:0]    last_node;

    assign scan_issue = i_cmd.scan_run && (r_scan != r_node);
    assign last_node  = (IDX_W + 1)'({r_count, 1'b0}) - 1'b1;

    assign o_stat.scan_done    = (r_scan == r_node) && !r_rd_vld;
    assign o_stat.build_done   = ({1'b0, r_node} == last_node);
    assign o_stat.c_has_parent = r_hp[r_c];
    assign o_stat.leaf_last    = (r_leaf == r_count - 1'b1);
    assign o_stat.out_free     = !o_valid || i_ready;

    always_comb begin
        wt_we = 1'b0;
        wt_wa = r_node;
        wt_wd = r_a_w + r_best_w;
        if (i_cmd.load) begin
            wt_we = (r_count != CNT_W'(MAX_SYMBOLS));
            wt_wa = IDX_W'(r_count);
            wt_wd = WT_W'(i_weight);
        end else if (i_cmd.pick_b) begin
            wt_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            m_weight[wt_wa] <= wt_wd;
        end
        r_rd_w <= m_weight[r_scan];
        if (i_cmd.load && r_count != CNT_W'(MAX_SYMBOLS)) begin
            m_sym[r_count[SYM_AW-1:0]] <= i_symbol;
        end
        if (i_cmd.walk_start) begin
            r_sym <= m_sym[r_leaf[SYM_AW-1:0]];
        end
        if (i_cmd.pick_a) begin
            m_parent[r_best] <= {1'b0, r_node};
        end else if (i_cmd.pick_b) begin
            m_parent[r_best] <= {1'b1, r_node};
        end
        if (i_cmd.walk_rd) begin
            r_par <= m_parent[r_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_hp     <= '0;
            r_node   <= '0;
            r_scan   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_leaf   <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_count != CNT_W'(MAX_SYMBOLS)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.clear || i_cmd.pick_a || i_cmd.pick_b) begin
                r_scan   <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_hp   <= '0;
                r_node <= IDX_W'(r_count);
            end
            if (i_cmd.pick_a) begin
                r_hp[r_best] <= 1'b1;
                r_a_w        <= r_best_w;
            end
            if (i_cmd.pick_b) begin
                r_hp[r_best] <= 1'b1;
                r_node       <= r_node + 1'b1;
            end
            if (i_cmd.scan_run) begin
                r_rd_vld <= scan_issue;
                r_rd_idx <= r_scan;
                if (scan_issue) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (r_rd_vld && !r_hp[r_rd_idx] && (!r_found || r_rd_w < r_best_w)) begin
                    r_found  <= 1'b1;
                    r_best   <= r_rd_idx;
                    r_best_w <= r_rd_w;
                end
            end
            if (i_cmd.emit_start) begin
                r_leaf <= '0;
            end
            if (i_cmd.next_leaf) begin
                r_leaf <= r_leaf + 1'b1;
            end
            if (i_cmd.walk_start) begin
                r_c    <= IDX_W'(r_leaf);
                r_len  <= '0;
                r_code <= '0;
            end
            if (i_cmd.walk_upd) begin
                if (r_len != LEN_W'(CODE_W)) begin
                    r_code[r_len] <= r_par[IDX_W];
                    r_len         <= r_len + 1'b1;
                end
                r_c <= r_par[IDX_W-1:0];
            end
            if (i_cmd.out_push) begin
                o_valid  <= 1'b1;
                o_symbol <= r_sym;
                o_code   <= r_code;
                o_len    <= r_len;
                o_final  <= o_stat.leaf_last;
                if (r_count < CNT_W'(2)) begin
                    o_status <= STAT_SINGLE;
                end else if (r_ovf) begin
                    o_status <= STAT_DROP;
                end else begin
                    o_status <= STAT_OK;
                end
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (i_cmd.done_clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end
endmodule

/* design/huffman_code_builder_unit.sv */
// Huffman code builder top level: joins controller and datapath.
// Depends on hcb_pkg, hcb_ctrl, hcb_dp.
//
// channel  dir  tdata (low bit up)                              tlast
// s_axis   in   symbol[7:0] weight[23:8]                        last
// m_axis   out  out_symbol[7:0] code[38:8] code_length[43:39]   final_res
//               status[45:44], zero pad[47:46]
//
// Load: one item per cycle while the input is open. Build: each of the n-1
// merges runs two scans over the nodes made so far through the one
// weight-memory read port. Emit: per leaf, the code is walked up the tree one
// level at a time, then the result is pushed. Input is held off from the
// last item until the final result is registered. Synchronous active-low reset.
`timescale 1ns / 1ps
module huffman_code_builder_unit
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // symbol, weight
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_symbol, code, code_length, status
    output logic        m_axis_tlast
);
    t_cmd  cmd;
    t_stat stat;

    logic [SYM_W-1:0]  out_sym;
    logic [CODE_W-1:0] out_code;
    logic [LEN_W-1:0]  out_len;
    logic [STAT_W-1:0] out_status;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hcb_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_symbol (s_axis_tdata[7:0]),
        .i_weight (s_axis_tdata[23:8]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_symbol (out_sym),
        .o_code   (out_code),
        .o_len    (out_len),
        .o_status (out_status),
        .o_final  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_status, out_len, out_code, out_sym};

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.clear, cmd.scan_run, cmd.pick_a, cmd.pick_b,
                  cmd.walk_start, cmd.walk_rd, cmd.walk_upd, cmd.out_push}))
        else $error("more than one datapath command");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_push |-> stat.out_free)
        else $error("result pushed over a waiting result");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[45:44] == STAT_SINGLE)
        |-> (m_axis_tdata[43:39] == 5'd0 && m_axis_tlast))
        else $error("single-symbol result malformed");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pick_a || cmd.pick_b || cmd.walk_upd) |-> !s_axis_tready)
        else $error("input open during build");
endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for huffman_code_builder_unit: loads symbol/weight sets,
// predicts each code table in-bench and checks every result item.
// Depends on hcb_pkg and the huffman_code_builder_unit RTL.
`timescale 1ns / 1ps
module testbench;
    import hcb_pkg::*;

    localparam int LEAF_CAP = MAX_SYMBOLS_DEF;
    localparam int NODE_CAP = 2 * LEAF_CAP - 1;
    localparam int RANDOM_ITEMS = 460;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [STAT_W-1:0] status;
        logic              fin;
    } t_code_entry;

    typedef struct {
        logic [SYM_W-1:0]    sym;
        logic [WEIGHT_W-1:0] wt;
        logic                last;
        logic                typed;
        t_code_entry         typed_res;
    } t_load_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // symbol, weight
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // out_symbol, code, code_length, status
    logic m_axis_tlast;

    huffman_code_builder_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [SYM_W-1:0]    leaf_sym [LEAF_CAP];
    logic [WEIGHT_W-1:0] leaf_wt [LEAF_CAP];
    int                  leaves_held = 0;
    bit                  leaves_dropped = 0;
    t_code_entry         built_codes[$];
    t_code_entry         pending_codes[$];

    int mismatches = 0;
    int send_idle_pct = 13;
    int recv_idle_pct = 61;

    // Loads one leaf; on last builds the tree and fills built_codes.
    task automatic predict_codes(input logic [SYM_W-1:0] sym, input logic [WEIGHT_W-1:0] wt,
                                 input logic last);
        logic [20:0] nw [NODE_CAP];
        int par [NODE_CAP];
        int lft [NODE_CAP];
        bit hasp [NODE_CAP];
        int n, a, b, c, len, pick;
        logic [CODE_W-1:0] code;
        logic [STAT_W-1:0] st;
        built_codes.delete();
        if (leaves_held < LEAF_CAP) begin
            leaf_sym[leaves_held] = sym;
            leaf_wt[leaves_held] = wt;
            leaves_held++;
        end else begin
            leaves_dropped = 1;
        end
        if (!last) return;
        n = leaves_held;
        st = leaves_dropped ? STAT_DROP : STAT_OK;
        if (n < 2) begin
            built_codes.push_back('{leaf_sym[0], '0, '0, STAT_SINGLE, 1'b1});
        end else begin
            for (int i = 0; i < 2 * n - 1; i++) begin
                hasp[i] = 0;
                par[i] = 0;
                if (i < n) nw[i] = {5'd0, leaf_wt[i]};
            end
            for (int i = n; i < 2 * n - 1; i++) begin
                for (int k = 0; k < 2; k++) begin
                    pick = -1;
                    for (int j = 0; j < i; j++)
                        if (!hasp[j] && (pick < 0 || nw[j] < nw[pick])) pick = j;
                    hasp[pick] = 1;
                    par[pick] = i;
                    if (k == 0) a = pick; else b = pick;
                end
                lft[i] = a;
                nw[i] = nw[a] + nw[b];
            end
            for (int i = 0; i < n; i++) begin
                c = i;
                len = 0;
                code = '0;
                while (hasp[c]) begin
                    if (len < CODE_W && lft[par[c]] != c) code[len] = 1'b1;
                    if (len < CODE_W) len++;
                    c = par[c];
                end
                built_codes.push_back('{leaf_sym[i], code, len[LEN_W-1:0], st, i == n - 1});
            end
        end
        leaves_held = 0;
        leaves_dropped = 0;
    endtask

    task automatic send_leaf(input t_load_row row);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {row.wt, row.sym};
        s_axis_tlast <= row.last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_codes(row.sym, row.wt, row.last);
        if (row.typed && row.last) pending_codes.push_back(row.typed_res);
        else foreach (built_codes[k]) pending_codes.push_back(built_codes[k]);
    endtask

    task automatic drain_pending();
        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_code_entry exp_res, got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[7:0], m_axis_tdata[38:8], m_axis_tdata[43:39],
                        m_axis_tdata[45:44], m_axis_tlast};
                if (pending_codes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %p", got);
                end else begin
                    exp_res = pending_codes.pop_front();
                    if (got !== exp_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", exp_res, got);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    t_load_row directed [20];

    initial begin
        t_load_row row;
        int items, set_len, mode;
        directed = '{
            '{8'h41, 16'd0,     1, 1, '{8'h41, '0, '0, STAT_SINGLE, 1'b1}},
            '{8'hFF, 16'hFFFF,  1, 1, '{8'hFF, '0, '0, STAT_SINGLE, 1'b1}},
            '{8'h00, 16'd0,     1, 1, '{8'h00, '0, '0, STAT_SINGLE, 1'b1}},
            '{8'h01, 16'd5,     0, 0, '0},
            '{8'h02, 16'd5,     1, 0, '0},
            '{8'h03, 16'hFFFF,  0, 0, '0},
            '{8'h04, 16'd0,     1, 0, '0},
            '{8'h10, 16'd0,     0, 0, '0},
            '{8'h11, 16'd0,     0, 0, '0},
            '{8'h12, 16'd0,     0, 0, '0},
            '{8'h13, 16'd0,     0, 0, '0},
            '{8'h14, 16'd0,     1, 0, '0},
            '{8'h80, 16'hFFFF,  0, 0, '0},
            '{8'h7F, 16'hFFFF,  0, 0, '0},
            '{8'hC3, 16'hFFFF,  0, 0, '0},
            '{8'h3C, 16'hFFFF,  1, 0, '0},
            '{8'hAA, 16'd1,     0, 0, '0},
            '{8'h55, 16'd2,     0, 0, '0},
            '{8'h0F, 16'd3,     0, 0, '0},
            '{8'hF0, 16'd4,     1, 0, '0}
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_leaf(directed[k]);
        drain_pending();

        items = 0;
        while (items < RANDOM_ITEMS) begin
            if (items >= 150 && send_idle_pct == 13) begin
                drain_pending();
                send_idle_pct = 61;
                recv_idle_pct = 13;
            end else if (items >= 300 && send_idle_pct == 61) begin
                drain_pending();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mode = $urandom_range(99);
            if (mode < 60) set_len = $urandom_range(2, 8);
            else if (mode < 80) set_len = $urandom_range(9, 20);
            else if (mode < 90) set_len = $urandom_range(21, 32);
            else if (mode < 95) set_len = 1;
            else set_len = $urandom_range(33, 36);
            mode = $urandom_range(3);
            for (int k = 0; k < set_len; k++) begin
                row.sym = SYM_W'($urandom_range(255));
                case (mode)
                    0: row.wt = WEIGHT_W'($urandom_range(65535));
                    1: row.wt = WEIGHT_W'($urandom_range(3));
                    2: row.wt = 16'd1 << $urandom_range(15);
                    default: row.wt = ($urandom_range(1)) ? 16'hFFFF
                                                          : WEIGHT_W'($urandom_range(65535));
                endcase
                row.last = (k == set_len - 1);
                row.typed = 0;
                row.typed_res = '0;
                send_leaf(row);
                items++;
            end
        end
        drain_pending();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_codes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
